// ===== src/haptic_event_slot_mixer_core_defines.svh =====
// Assertion helpers for the haptic event slot mixer
`ifndef HAPTIC_EVENT_SLOT_MIXER_CORE_DEFINES_SVH
`define HAPTIC_EVENT_SLOT_MIXER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define HESM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define HESM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hesm_pkg.sv =====
package hesm_pkg;

  localparam int unsigned SLOTS_PER_HAND_DEF = 4;
  localparam int unsigned ORDER_WIDTH_DEF    = 32;

  localparam int unsigned US_W    = 20;
  localparam int unsigned INT_W   = 16;
  localparam int unsigned ACT_W   = 5;
  localparam int unsigned LIM_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned SLOT_W  = 2 * INT_W + 2 * US_W;

  localparam logic [US_W-1:0]  MAX_DUR_RST   = 20'd200000;
  localparam logic [US_W-1:0]  PULSE_MIN_RST = 20'd5000;
  localparam logic [US_W-1:0]  PULSE_MAX_RST = 20'd20000;
  localparam logic [US_W-1:0]  DEF_TICK_RST  = 20'd11111;
  localparam logic [LIM_W-1:0] OUT_LIM_RST   = 2'd2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_DUR   = 3'd0,
    REG_PULSE_MIN = 3'd1,
    REG_PULSE_MAX = 3'd2,
    REG_DEF_TICK  = 3'd3,
    REG_OUT_LIM   = 3'd4
  } reg_idx_t;

  localparam logic OP_QUEUE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // One slot word in the event RAM
  typedef struct packed {
    logic [INT_W-1:0] start;
    logic [INT_W-1:0] fin;
    logic [US_W-1:0]  dur;
    logic [US_W-1:0]  elapsed;
  } slot_t;

  // One buffered result
  typedef struct packed {
    logic             hand;
    logic [INT_W-1:0] intensity;
    logic [US_W-1:0]  pulse;
    logic [ACT_W-1:0] active;
  } res_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_QSCAN = 9'b000000010,
    ST_QWR   = 9'b000000100,
    ST_TRD   = 9'b000001000,
    ST_TPROC = 9'b000010000,
    ST_TFIN  = 9'b000100000,
    ST_MUL   = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_t;

endpackage

// ===== src/hesm_ram.sv =====
module hesm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/haptic_event_slot_mixer_core.sv =====
// Haptic event slot mixer. Holds SLOTS_PER_HAND vibration events per hand in
// one single-port-write RAM with registered read. A queue beat (tuser op 0)
// runs a slot search over the order numbers, then the write; a dropped event
// is taken in idle with no search. A tick beat (tuser op 1) walks each hand's
// slots (RAM read, then age and write back for each slot) and then a finish
// step, then for an emitting hand runs a multiply and a 16-step restoring
// divide for the ramp (the divide is skipped for a duration of 1 or less),
// then delivers the buffered results, waiting while the output stalls. Input
// is taken only between beats; a result left waiting at the output does not
// hold off the next input beat. Slot data is undefined until written; no
// clearing pass is run after reset.
`include "haptic_event_slot_mixer_core_defines.svh"

module haptic_event_slot_mixer_core #(
  parameter int unsigned SLOTS_PER_HAND = hesm_pkg::SLOTS_PER_HAND_DEF,
  parameter int unsigned ORDER_WIDTH    = hesm_pkg::ORDER_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: hand[0], duration_us[20:1], start_intensity[36:21],
  //        end_intensity[52:37], tick_us[72:53], zero fill
  input  logic [hesm_pkg::IN_DATA_W-1:0]   in_tdata,
  // tuser: op[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: intensity[15:0], pulse_us[35:16], active_slots[40:36], zero fill
  output logic [hesm_pkg::OUT_DATA_W-1:0]  out_tdata,
  // tuser: out_hand[0]
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [hesm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hesm_pkg::US_W-1:0]        cfg_wdata
);

  localparam int unsigned NSLOT = 2 * SLOTS_PER_HAND;
  localparam int unsigned SW    = $clog2(NSLOT);
  localparam int unsigned LW    = (SLOTS_PER_HAND > 1) ? $clog2(SLOTS_PER_HAND) : 1;
  localparam int unsigned US_W  = hesm_pkg::US_W;
  localparam int unsigned INT_W = hesm_pkg::INT_W;
  localparam int unsigned PROD_W = INT_W + US_W;
  localparam int unsigned NUM_W  = PROD_W + 1;
  localparam int unsigned REM_W  = US_W + 1;
  localparam int unsigned DCNT_W = $clog2(INT_W);

  // Configuration registers
  logic [US_W-1:0]            max_dur_r, pulse_min_r, pulse_max_r, def_tick_r;
  logic [hesm_pkg::LIM_W-1:0] out_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dur_r   <= hesm_pkg::MAX_DUR_RST;
      pulse_min_r <= hesm_pkg::PULSE_MIN_RST;
      pulse_max_r <= hesm_pkg::PULSE_MAX_RST;
      def_tick_r  <= hesm_pkg::DEF_TICK_RST;
      out_lim_r   <= hesm_pkg::OUT_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hesm_pkg::REG_MAX_DUR:   max_dur_r   <= cfg_wdata;
        hesm_pkg::REG_PULSE_MIN: pulse_min_r <= cfg_wdata;
        hesm_pkg::REG_PULSE_MAX: pulse_max_r <= cfg_wdata;
        hesm_pkg::REG_DEF_TICK:  def_tick_r  <= cfg_wdata;
        hesm_pkg::REG_OUT_LIM:   out_lim_r   <= cfg_wdata[hesm_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input beat
  logic             in_hand;
  logic [US_W-1:0]  in_dur, in_tick;
  logic [INT_W-1:0] in_st, in_en;
  assign in_hand = in_tdata[0];
  assign in_dur  = in_tdata[20:1];
  assign in_st   = in_tdata[36:21];
  assign in_en   = in_tdata[52:37];
  assign in_tick = in_tdata[72:53];

  logic [US_W-1:0] dur_c, delta_c, tick_lo, tick_c;
  logic            q_drop;
  assign dur_c   = (in_dur > max_dur_r) ? max_dur_r : in_dur;
  assign q_drop  = (dur_c == '0) || ((in_st == '0) && (in_en == '0));
  assign delta_c = (in_tick == '0) ? def_tick_r : in_tick;
  assign tick_lo = (delta_c < pulse_min_r) ? pulse_min_r : delta_c;
  assign tick_c  = (tick_lo > pulse_max_r) ? pulse_max_r : tick_lo;

  hesm_pkg::state_t state_r, state_nxt;
  logic                   hand_r;
  logic [LW-1:0]          idx_r;
  logic [SW-1:0]          slot_addr;
  logic                   live_r [NSLOT];
  logic [ORDER_WIDTH-1:0] order_r [NSLOT];
  logic [ORDER_WIDTH-1:0] next_order_r, best_order_r, next_order_inc;
  logic                   found_r;
  logic [LW-1:0]          pick_r;
  hesm_pkg::slot_t        q_slot_r, best_r, rd_slot, wr_slot;
  logic [US_W-1:0]        delta_r, tickc_r;
  logic [hesm_pkg::ACT_W-1:0] lcnt_r;
  logic [PROD_W-1:0]      prod_r;
  logic [REM_W-1:0]       rem_r;
  logic [INT_W-1:0]       quo_r;
  logic [DCNT_W-1:0]      dcnt_r;
  logic                   dinit_r;
  hesm_pkg::res_t         res_r [2];
  logic [1:0]             rcnt_r;
  logic                   eidx_r;
  logic                   ram_we;
  logic [SW-1:0]          ram_waddr;
  logic                   idx_last;

  assign slot_addr = hand_r ? (SW'(SLOTS_PER_HAND) + SW'(idx_r)) : SW'(idx_r);
  assign idx_last  = (idx_r == LW'(SLOTS_PER_HAND - 1));
  assign in_tready = (state_r == hesm_pkg::ST_IDLE);
  assign next_order_inc = next_order_r + ORDER_WIDTH'(1);

  // Event RAM
  logic [hesm_pkg::SLOT_W-1:0] ram_rdata;
  hesm_ram #(.WIDTH(hesm_pkg::SLOT_W), .DEPTH(NSLOT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_slot),
    .raddr (slot_addr),
    .rdata (ram_rdata)
  );
  assign rd_slot = hesm_pkg::slot_t'(ram_rdata);

  // Age the slot just read
  logic [US_W:0]   age_sum;
  logic [US_W-1:0] age_el;
  logic            pre_dead;
  assign age_sum  = {1'b0, rd_slot.elapsed} + {1'b0, delta_r};
  assign age_el   = age_sum[US_W] ? {US_W{1'b1}} : age_sum[US_W-1:0];
  assign pre_dead = rd_slot.elapsed >= rd_slot.dur;

  always_comb begin
    wr_slot   = rd_slot;
    ram_we    = 1'b0;
    ram_waddr = slot_addr;
    if (state_r == hesm_pkg::ST_QWR) begin
      wr_slot   = q_slot_r;
      ram_we    = 1'b1;
      ram_waddr = hand_r ? (SW'(SLOTS_PER_HAND) + SW'(pick_r)) : SW'(pick_r);
    end else if (state_r == hesm_pkg::ST_TPROC) begin
      wr_slot.elapsed = age_el;
      ram_we = live_r[slot_addr] && !pre_dead;
    end
  end

  // Ramp divide step
  logic [REM_W:0]  div_t;
  logic            div_ge;
  logic [INT_W-1:0] diff;
  logic [NUM_W-1:0] num;
  logic            up;
  assign up     = best_r.fin >= best_r.start;
  assign diff   = up ? (best_r.fin - best_r.start) : (best_r.start - best_r.fin);
  assign num    = {1'b0, prod_r} + NUM_W'(best_r.dur >> 1);
  assign div_t  = {rem_r, quo_r[INT_W-1]};
  assign div_ge = div_t >= {2'b0, best_r.dur};

  logic emit_ok;
  assign emit_ok = found_r && (rcnt_r < out_lim_r);

  // Load the output register when it is free or being taken
  logic emit_load;
  assign emit_load = (state_r == hesm_pkg::ST_EMIT) && (!out_tvalid || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hesm_pkg::ST_IDLE:
        if (in_tvalid) begin
          if (in_tuser == hesm_pkg::OP_TICK) state_nxt = hesm_pkg::ST_TRD;
          else if (!q_drop)                  state_nxt = hesm_pkg::ST_QSCAN;
        end
      hesm_pkg::ST_QSCAN: if (idx_last) state_nxt = hesm_pkg::ST_QWR;
      hesm_pkg::ST_QWR:   state_nxt = hesm_pkg::ST_IDLE;
      hesm_pkg::ST_TRD:   state_nxt = hesm_pkg::ST_TPROC;
      hesm_pkg::ST_TPROC: state_nxt = idx_last ? hesm_pkg::ST_TFIN : hesm_pkg::ST_TRD;
      hesm_pkg::ST_TFIN:
        if (emit_ok)            state_nxt = hesm_pkg::ST_MUL;
        else if (!hand_r)       state_nxt = hesm_pkg::ST_TRD;
        else if (rcnt_r != '0)  state_nxt = hesm_pkg::ST_EMIT;
        else                    state_nxt = hesm_pkg::ST_IDLE;
      hesm_pkg::ST_MUL:
        state_nxt = (best_r.dur <= US_W'(1)) ?
                    (hand_r ? hesm_pkg::ST_EMIT : hesm_pkg::ST_TRD) : hesm_pkg::ST_DIV;
      hesm_pkg::ST_DIV:
        if (!dinit_r && dcnt_r == DCNT_W'(INT_W - 1))
          state_nxt = hand_r ? hesm_pkg::ST_EMIT : hesm_pkg::ST_TRD;
      hesm_pkg::ST_EMIT:
        if (emit_load && (eidx_r == (rcnt_r == 2'd2)))
          state_nxt = hesm_pkg::ST_IDLE;
      default: state_nxt = hesm_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hesm_pkg::ST_IDLE;
      next_order_r <= ORDER_WIDTH'(1);
      rcnt_r       <= '0;
      out_tvalid   <= 1'b0;
      for (int i = 0; i < NSLOT; i++) begin
        live_r[i]  <= 1'b0;
        order_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (emit_load)       out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        hesm_pkg::ST_IDLE: begin
          idx_r        <= '0;
          hand_r       <= (in_tuser == hesm_pkg::OP_TICK) ? 1'b0 : in_hand;
          found_r      <= 1'b0;
          pick_r       <= '0;
          best_order_r <= '1;
          lcnt_r       <= '0;
          rcnt_r       <= '0;
          eidx_r       <= 1'b0;
          delta_r      <= delta_c;
          tickc_r      <= tick_c;
          q_slot_r     <= '{start: in_st, fin: in_en, dur: dur_c, elapsed: '0};
        end
        hesm_pkg::ST_QSCAN: begin
          if (!found_r) begin
            if (!live_r[slot_addr]) begin
              pick_r  <= idx_r;
              found_r <= 1'b1;
            end else if (order_r[slot_addr] < best_order_r) begin
              pick_r       <= idx_r;
              best_order_r <= order_r[slot_addr];
            end
          end
          idx_r <= idx_r + LW'(1);
        end
        hesm_pkg::ST_QWR: begin
          live_r[ram_waddr]  <= 1'b1;
          order_r[ram_waddr] <= next_order_r;
          next_order_r <= (next_order_inc == '0) ? ORDER_WIDTH'(1) : next_order_inc;
        end
        hesm_pkg::ST_TRD: ;
        hesm_pkg::ST_TPROC: begin
          if (live_r[slot_addr]) begin
            if (pre_dead) begin
              live_r[slot_addr] <= 1'b0;
            end else begin
              if (!found_r || order_r[slot_addr] > best_order_r) begin
                found_r      <= 1'b1;
                best_order_r <= order_r[slot_addr];
                best_r       <= rd_slot;
              end
              if (age_el >= rd_slot.dur) live_r[slot_addr] <= 1'b0;
              else                       lcnt_r <= lcnt_r + hesm_pkg::ACT_W'(1);
            end
          end
          idx_r <= idx_r + LW'(1);
        end
        hesm_pkg::ST_TFIN: begin
          if (emit_ok) begin
            res_r[rcnt_r[0]].hand   <= hand_r;
            res_r[rcnt_r[0]].pulse  <= ((best_r.dur - best_r.elapsed) < tickc_r) ?
                                       (best_r.dur - best_r.elapsed) : tickc_r;
            res_r[rcnt_r[0]].active <= lcnt_r;
          end else begin
            hand_r  <= 1'b1;
            idx_r   <= '0;
            found_r <= 1'b0;
            lcnt_r  <= '0;
          end
        end
        hesm_pkg::ST_MUL: begin
          prod_r  <= PROD_W'(diff) * PROD_W'(best_r.elapsed);
          dinit_r <= 1'b1;
          dcnt_r  <= '0;
          if (best_r.dur <= US_W'(1)) begin
            res_r[rcnt_r[0]].intensity <= best_r.fin;
            rcnt_r  <= rcnt_r + 2'd1;
            hand_r  <= 1'b1;
            idx_r   <= '0;
            found_r <= 1'b0;
            lcnt_r  <= '0;
          end
        end
        hesm_pkg::ST_DIV: begin
          if (dinit_r) begin
            rem_r   <= num[NUM_W-1:INT_W];
            quo_r   <= num[INT_W-1:0];
            dinit_r <= 1'b0;
          end else begin
            rem_r  <= div_ge ? REM_W'(div_t - {2'b0, best_r.dur}) : div_t[REM_W-1:0];
            quo_r  <= {quo_r[INT_W-2:0], div_ge};
            dcnt_r <= dcnt_r + DCNT_W'(1);
            if (dcnt_r == DCNT_W'(INT_W - 1)) begin
              res_r[rcnt_r[0]].intensity <= up ?
                (best_r.start + {quo_r[INT_W-2:0], div_ge}) :
                (best_r.start - {quo_r[INT_W-2:0], div_ge});
              rcnt_r  <= rcnt_r + 2'd1;
              hand_r  <= 1'b1;
              idx_r   <= '0;
              found_r <= 1'b0;
              lcnt_r  <= '0;
            end
          end
        end
        hesm_pkg::ST_EMIT: begin
          if (emit_load) begin
            out_tuser  <= res_r[eidx_r].hand;
            out_tdata  <= {7'd0, res_r[eidx_r].active, res_r[eidx_r].pulse,
                           res_r[eidx_r].intensity};
            out_tlast  <= (eidx_r == (rcnt_r == 2'd2));
            eidx_r     <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Checks
  `HESM_ASSERT_NOW(a_ram_we_state, ram_we,
    (state_r == hesm_pkg::ST_QWR) || (state_r == hesm_pkg::ST_TPROC),
    "event RAM written outside a write state")
  `HESM_ASSERT_NEXT(a_queue_live, state_r == hesm_pkg::ST_QWR,
    live_r[$past(ram_waddr)], "queued slot not marked live")
  `HESM_ASSERT_NOW(a_order_nonzero, state_r == hesm_pkg::ST_QWR,
    next_order_r != '0, "sequence counter reached zero")
  `HESM_ASSERT_NOW(a_emit_has_res, state_r == hesm_pkg::ST_EMIT,
    (rcnt_r == 2'd1) || (rcnt_r == 2'd2), "emit state without a buffered result")

endmodule
